// ===== rtl/core/dltr_pkg.sv =====
`timescale 1ns / 1ps

package dltr_pkg;

  localparam int DW = 16;
  localparam int FRAC = 8;
  localparam int LR_W = 16;
  localparam int CNT_W = 7;
  localparam int POS_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 32;
  localparam int OUT_TDATA_W = 24;

  localparam int DEF_MAX_INPUTS = 64;
  localparam int DEF_MAX_OUTPUTS = 64;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RELU_ENABLE = CFG_IDX_W'(3);

  localparam logic [LR_W-1:0] LR_RESET = LR_W'(655);

  typedef enum logic [1:0] {
    OP_WEIGHT,
    OP_INPUT,
    OP_DELTA,
    OP_UPDATE
  } op_t;

  typedef enum logic [1:0] {
    K_FWD,
    K_BWD,
    K_UPD,
    K_LD
  } kind_t;

  typedef struct packed {
    logic             valid;
    kind_t            kind;
    logic             first;
    logic             last;
    logic             bias;
    logic [POS_W-1:0] pos;
    logic             out_last;
    logic             host_wr;
    logic             in_wr;
    logic             dl_wr;
  } cmd_t;

  typedef struct packed {
    logic res_done;
    logic pipe_empty;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [LR_W-1:0] lr;
    logic            relu;
  } cfg_t;

endpackage

// ===== rtl/core/dltr_ctrl.sv =====
`timescale 1ns / 1ps

module dltr_ctrl
  import dltr_pkg::*;
#(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  localparam int ROW_LEN = MAX_INPUTS + 1,
  localparam int WA = $clog2(MAX_OUTPUTS * ROW_LEN),
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,
  input  stat_t                  stat,
  output cmd_t                   cmd,
  output logic [WA-1:0]          w_addr,
  output logic [IW-1:0]          in_idx,
  output logic [OW-1:0]          dl_idx,
  output logic [DW-1:0]          host_data,
  output cfg_t                   cfg
);

  localparam int CW = $clog2(MAX_INPUTS + 1);
  localparam int RW = $clog2(MAX_OUTPUTS + 1);
  localparam int XW = 11;
  localparam int NIN_RST = (MAX_INPUTS < 64) ? MAX_INPUTS : 64;
  localparam int NOUT_RST = (MAX_OUTPUTS < 64) ? MAX_OUTPUTS : 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FWD_GATE,
    S_FWD_ISSUE,
    S_FWD_WAIT,
    S_BWD_GATE,
    S_BWD_ISSUE,
    S_BWD_WAIT,
    S_UPD_LD,
    S_UPD_ISSUE,
    S_UPD_DRAIN
  } state_t;

  state_t          state;
  logic [CW-1:0]   nin;
  logic [RW-1:0]   nout;
  logic [LR_W-1:0] lr;
  logic            relu;
  logic [CW-1:0]   icol;
  logic [RW-1:0]   orow;
  logic [WA-1:0]   base;
  logic [WA-1:0]   waddr;

  logic [POS_W-1:0] row_f;
  logic [CNT_W-1:0] col_f;
  op_t              op;
  logic             accept;
  logic [XW-1:0]    col_x;
  logic [XW-1:0]    row_x;
  logic [XW-1:0]    nin_x;
  logic [XW-1:0]    nout_x;
  logic [CW-1:0]    nin_m1;
  logic [RW-1:0]    nout_m1;
  logic             col_is_bias;
  logic             wr_ok;
  logic             in_ok;
  logic             dl_ok;
  logic [WA-1:0]    host_addr;
  logic [WA-1:0]    row_addr;
  logic [CNT_W-1:0] cfg_cnt;
  logic [XW-1:0]    cfg_cnt_x;
  logic [CW-1:0]    nin_next;
  logic [RW-1:0]    nout_next;

  assign row_f = s_tdata[POS_W-1:0];
  assign col_f = s_tdata[POS_W+CNT_W-1:POS_W];
  assign host_data = s_tdata[POS_W+CNT_W+DW-1:POS_W+CNT_W];
  assign op = op_t'(s_tuser);
  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg.lr = lr;
  assign cfg.relu = relu;

  assign col_x = XW'(col_f);
  assign row_x = XW'(row_f);
  assign nin_x = XW'(nin);
  assign nout_x = XW'(nout);
  assign nin_m1 = nin - CW'(1);
  assign nout_m1 = nout - RW'(1);
  assign col_is_bias = (col_x == nin_x);
  assign wr_ok = (row_x < nout_x) && (col_x <= nin_x);
  assign in_ok = (col_x < nin_x);
  assign dl_ok = (row_x < nout_x);
  assign host_addr = WA'(row_f) * WA'(ROW_LEN)
                   + (col_is_bias ? WA'(MAX_INPUTS) : WA'(col_f));
  assign row_addr = base + ((icol == nin) ? WA'(MAX_INPUTS) : WA'(icol));

  assign cfg_cnt = cfg_data[CNT_W-1:0];
  assign cfg_cnt_x = XW'(cfg_cnt);
  assign nin_next = (cfg_cnt == '0) ? CW'(1)
                  : (cfg_cnt_x > XW'(MAX_INPUTS)) ? CW'(MAX_INPUTS) : CW'(cfg_cnt);
  assign nout_next = (cfg_cnt == '0) ? RW'(1)
                   : (cfg_cnt_x > XW'(MAX_OUTPUTS)) ? RW'(MAX_OUTPUTS) : RW'(cfg_cnt);

  always_comb begin
    cmd = '0;
    cmd.kind = K_FWD;
    w_addr = host_addr;
    in_idx = IW'(col_f);
    dl_idx = OW'(row_f);
    unique case (state)
      S_FWD_ISSUE: begin
        cmd.valid = 1'b1;
        cmd.kind = K_FWD;
        cmd.first = (icol == '0);
        cmd.last = (icol == nin);
        cmd.bias = (icol == nin);
        cmd.pos = POS_W'(orow);
        cmd.out_last = (orow == nout_m1);
        w_addr = row_addr;
        in_idx = IW'(icol);
      end
      S_BWD_ISSUE: begin
        cmd.valid = 1'b1;
        cmd.kind = K_BWD;
        cmd.first = (orow == '0);
        cmd.last = (orow == nout_m1);
        cmd.pos = POS_W'(icol);
        cmd.out_last = (icol == nin_m1);
        w_addr = waddr;
        dl_idx = OW'(orow);
      end
      S_UPD_LD: begin
        cmd.valid = 1'b1;
        cmd.kind = K_LD;
        dl_idx = OW'(orow);
      end
      S_UPD_ISSUE: begin
        cmd.valid = 1'b1;
        cmd.kind = K_UPD;
        cmd.first = (icol == '0);
        cmd.last = (icol == nin);
        cmd.bias = (icol == nin);
        w_addr = row_addr;
        in_idx = IW'(icol);
      end
      S_IDLE: begin
        cmd.host_wr = accept && (op == OP_WEIGHT) && wr_ok;
        cmd.in_wr = accept && (op == OP_INPUT) && in_ok;
        cmd.dl_wr = accept && (op == OP_DELTA) && dl_ok;
      end
      default: begin
        cmd.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nin <= CW'(NIN_RST);
      nout <= RW'(NOUT_RST);
      lr <= LR_RESET;
      relu <= 1'b1;
      icol <= '0;
      orow <= '0;
      base <= '0;
      waddr <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NUM_INPUTS: nin <= nin_next;
          REG_NUM_OUTPUTS: nout <= nout_next;
          REG_LEARNING_RATE: lr <= cfg_data[LR_W-1:0];
          REG_RELU_ENABLE: relu <= cfg_data[0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          icol <= '0;
          orow <= '0;
          base <= '0;
          waddr <= '0;
          if (accept) begin
            unique case (op)
              OP_INPUT: begin
                if (in_ok && (col_x == XW'(nin_m1))) begin
                  state <= S_FWD_GATE;
                end
              end
              OP_DELTA: begin
                if (dl_ok && (row_x == XW'(nout_m1))) begin
                  state <= S_BWD_GATE;
                end
              end
              OP_UPDATE: state <= S_UPD_LD;
              default: begin
              end
            endcase
          end
        end
        S_FWD_GATE: begin
          if (stat.out_free) begin
            state <= S_FWD_ISSUE;
          end
        end
        S_FWD_ISSUE: begin
          if (icol == nin) begin
            state <= S_FWD_WAIT;
          end else begin
            icol <= icol + CW'(1);
          end
        end
        S_FWD_WAIT: begin
          if (stat.res_done) begin
            if (orow == nout_m1) begin
              state <= S_IDLE;
            end else begin
              orow <= orow + RW'(1);
              base <= base + WA'(ROW_LEN);
              icol <= '0;
              state <= S_FWD_GATE;
            end
          end
        end
        S_BWD_GATE: begin
          if (stat.out_free) begin
            state <= S_BWD_ISSUE;
          end
        end
        S_BWD_ISSUE: begin
          if (orow == nout_m1) begin
            state <= S_BWD_WAIT;
          end else begin
            orow <= orow + RW'(1);
            waddr <= waddr + WA'(ROW_LEN);
          end
        end
        S_BWD_WAIT: begin
          if (stat.res_done) begin
            if (icol == nin_m1) begin
              state <= S_IDLE;
            end else begin
              icol <= icol + CW'(1);
              orow <= '0;
              waddr <= WA'(icol) + WA'(1);
              state <= S_BWD_GATE;
            end
          end
        end
        S_UPD_LD: state <= S_UPD_ISSUE;
        S_UPD_ISSUE: begin
          if (icol == nin) begin
            icol <= '0;
            if (orow == nout_m1) begin
              state <= S_UPD_DRAIN;
            end else begin
              orow <= orow + RW'(1);
              base <= base + WA'(ROW_LEN);
              state <= S_UPD_LD;
            end
          end else begin
            icol <= icol + CW'(1);
          end
        end
        S_UPD_DRAIN: begin
          if (stat.pipe_empty) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dltr_datapath.sv =====
`timescale 1ns / 1ps

module dltr_datapath
  import dltr_pkg::*;
#(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
  localparam int ROW_LEN = MAX_INPUTS + 1,
  localparam int WA = $clog2(MAX_OUTPUTS * ROW_LEN),
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1,
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [WA-1:0]          w_addr,
  input  logic [IW-1:0]          in_idx,
  input  logic [OW-1:0]          dl_idx,
  input  logic [DW-1:0]          host_data,
  input  cfg_t                   cfg,
  output stat_t                  stat,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int WDEPTH = MAX_OUTPUTS * ROW_LEN;
  localparam int LDW = LR_W + DW + 1;
  localparam int PW = LDW + DW;
  localparam int AW = 2 * DW + $clog2(MAX_INPUTS + MAX_OUTPUTS + 2) + 1;
  localparam logic signed [PW-1:0] HALF_X = PW'(1) <<< (LR_W + FRAC - 1);
  localparam logic signed [PW-1:0] HALF_B = PW'(1) <<< (LR_W - 1);
  localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (FRAC - 1);
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW-1:0] wmem [WDEPTH];
  logic [DW-1:0] imem [MAX_INPUTS];
  logic [DW-1:0] dmem [MAX_OUTPUTS];

  cmd_t                    c1;
  cmd_t                    c2;
  cmd_t                    c3;
  logic [WA-1:0]           a1;
  logic [WA-1:0]           a2;
  logic signed [DW-1:0]    w_q;
  logic signed [DW-1:0]    x_q;
  logic signed [DW-1:0]    d_q;
  logic signed [DW-1:0]    w2;
  logic signed [LDW-1:0]   ld;
  logic signed [PW-1:0]    p;
  logic signed [AW-1:0]    acc;

  logic signed [LDW-1:0]   ma;
  logic signed [DW-1:0]    mb;
  logic signed [PW-1:0]    mprod;
  logic signed [PW-1:0]    p_next;
  logic signed [PW-1:0]    rsum;
  logic signed [PW-1:0]    rnd;
  logic signed [PW:0]      diff;
  logic [DW-1:0]           neww;
  logic                    upd_wr;
  logic signed [AW-1:0]    asum;
  logic signed [AW-1:0]    z;
  logic [DW-1:0]           zsat;
  logic                    res_load;
  logic                    is_fwd3;

  logic [DW-1:0]           res;
  logic [POS_W-1:0]        pos;
  logic                    dir;
  logic                    posf;

  always_comb begin
    ma = {{(LDW-DW){x_q[DW-1]}}, x_q};
    mb = w_q;
    unique case (c1.kind)
      K_FWD: begin
        ma = {{(LDW-DW){x_q[DW-1]}}, x_q};
        mb = w_q;
      end
      K_BWD: begin
        ma = {{(LDW-DW){d_q[DW-1]}}, d_q};
        mb = w_q;
      end
      K_UPD: begin
        ma = ld;
        mb = x_q;
      end
      K_LD: begin
        ma = {{(LDW-LR_W){1'b0}}, cfg.lr};
        mb = d_q;
      end
      default: begin
        ma = ld;
        mb = x_q;
      end
    endcase
  end

  assign mprod = ma * mb;

  always_comb begin
    p_next = mprod;
    if (c1.bias && (c1.kind == K_FWD)) begin
      p_next = {{(PW-DW-FRAC){w_q[DW-1]}}, w_q, {FRAC{1'b0}}};
    end else if (c1.bias && (c1.kind == K_UPD)) begin
      p_next = {{(PW-LDW){ld[LDW-1]}}, ld};
    end
  end

  always_comb begin
    if (c2.bias) begin
      rsum = p + HALF_B;
      rnd = rsum >>> LR_W;
    end else begin
      rsum = p + HALF_X;
      rnd = rsum >>> (LR_W + FRAC);
    end
    diff = {{(PW+1-DW){w2[DW-1]}}, w2} - {rnd[PW-1], rnd};
    if ((&diff[PW:DW-1]) || !(|diff[PW:DW-1])) begin
      neww = diff[DW-1:0];
    end else begin
      neww = diff[PW] ? DMIN : DMAX;
    end
  end

  assign upd_wr = c2.valid && (c2.kind == K_UPD);

  always_comb begin
    asum = acc + HALF_A;
    z = asum >>> FRAC;
    if ((&z[AW-1:DW-1]) || !(|z[AW-1:DW-1])) begin
      zsat = z[DW-1:0];
    end else begin
      zsat = z[AW-1] ? DMIN : DMAX;
    end
  end

  assign is_fwd3 = (c3.kind == K_FWD);
  assign res_load = c3.valid && c3.last && (is_fwd3 || (c3.kind == K_BWD));

  assign stat.res_done = res_load;
  assign stat.pipe_empty = !c1.valid && !c2.valid;
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    w_q <= wmem[w_addr];
    x_q <= imem[in_idx];
    d_q <= dmem[dl_idx];
    if (cmd.in_wr) begin
      imem[in_idx] <= host_data;
    end
    if (cmd.dl_wr) begin
      dmem[dl_idx] <= host_data;
    end
    if (upd_wr) begin
      wmem[a2] <= neww;
    end else if (cmd.host_wr) begin
      wmem[w_addr] <= host_data;
    end
  end

  always_ff @(posedge clk) begin
    a1 <= w_addr;
    a2 <= a1;
    w2 <= w_q;
    p <= p_next;
    if (c1.valid && (c1.kind == K_LD)) begin
      ld <= mprod[LDW-1:0];
    end
    if (c2.valid && ((c2.kind == K_FWD) || (c2.kind == K_BWD))) begin
      acc <= (c2.first ? '0 : acc) + AW'(p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      m_tvalid <= 1'b0;
    end else begin
      c1 <= cmd;
      c2 <= c1;
      c3 <= c2;
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= (is_fwd3 && cfg.relu && zsat[DW-1]) ? '0 : zsat;
      posf <= is_fwd3 && !zsat[DW-1] && (|zsat);
      pos <= c3.pos;
      dir <= !is_fwd3;
      m_tlast <= c3.out_last;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-DW-POS_W){1'b0}}, pos, res};
  assign m_tuser = {posf, dir};

endmodule

// ===== rtl/core/dense_layer_train_engine.sv =====
`timescale 1ns / 1ps
// Weight writes, non-final input or delta items and rejected items leave the engine idle.
// The final input item runs num_outputs rows of num_inputs+1 multiply-accumulates
// on the single weight memory read port, each row starting once the output is free.
// The final delta item runs num_inputs columns; memories are not cleared.
// Synchronous active-high reset restores the register defaults and empties the pipeline.

module dense_layer_train_engine
  import dltr_pkg::*;
#(
  parameter int MAX_INPUTS = DEF_MAX_INPUTS,
  parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // row [5:0], col [12:6], value [28:13], zero above.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op [1:0].
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result [15:0], position [21:16], zero above.
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // direction [0], positive [1].
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int ROW_LEN = MAX_INPUTS + 1;
  localparam int WA = $clog2(MAX_OUTPUTS * ROW_LEN);
  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

  cmd_t          cmd;
  stat_t         stat;
  cfg_t          cfg;
  logic [WA-1:0] w_addr;
  logic [IW-1:0] in_idx;
  logic [OW-1:0] dl_idx;
  logic [DW-1:0] host_data;

  dltr_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .stat      (stat),
    .cmd       (cmd),
    .w_addr    (w_addr),
    .in_idx    (in_idx),
    .dl_idx    (dl_idx),
    .host_data (host_data),
    .cfg       (cfg)
  );

  dltr_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .w_addr    (w_addr),
    .in_idx    (in_idx),
    .dl_idx    (dl_idx),
    .host_data (host_data),
    .cfg       (cfg),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  a_result_into_free_reg: assert property (@(posedge clk) disable iff (rst)
    stat.res_done |-> !m_tvalid)
    else $error("result arrived while the output register was occupied");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> stat.pipe_empty)
    else $error("input accepted while the pipeline still works");

  a_no_issue_when_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> !s_tready)
    else $error("pipeline issue while accepting items");

endmodule

// ===== tb/dense_layer_train_engine_checker.sv =====
`timescale 1ns / 1ps

module dense_layer_train_engine_checker
  import dltr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  // row [5:0], col [12:6], value [28:13], zero above.
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // op [1:0].
  input  logic [1:0]             s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // result [15:0], position [21:16], zero above.
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  // direction [0], positive [1].
  input  logic [1:0]             m_tuser,
  input  logic                   m_tlast,
  output int                     errors,
  output int                     pending
);

  localparam int ROW_LEN = DEF_MAX_INPUTS + 1;

  typedef struct packed {
    logic [15:0] result;
    logic [5:0]  position;
    logic        direction;
    logic        positive;
    logic        last;
  } layer_out_t;

  layer_out_t  layer_out_q[$];
  longint      weights[DEF_MAX_OUTPUTS*ROW_LEN];
  longint      inputs_mem[DEF_MAX_INPUTS];
  longint      deltas_mem[DEF_MAX_OUTPUTS];
  int unsigned n_in;
  int unsigned n_out;
  longint      lr;
  bit          relu;

  assign pending = layer_out_q.size();

  initial begin
    errors = 0;
    foreach (weights[i]) weights[i] = 0;
    foreach (inputs_mem[i]) inputs_mem[i] = 0;
    foreach (deltas_mem[i]) deltas_mem[i] = 0;
  end

  function automatic longint round_q(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int unsigned clamp_count(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("Mismatch on %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  task automatic run_layer_item(input op_t op, input int unsigned row, input int unsigned col,
                                input longint val);
    longint      acc;
    longint      z;
    longint      ld;
    layer_out_t  o;
    case (op)
      OP_WEIGHT: begin
        if (row < n_out && col <= n_in)
          weights[row*ROW_LEN + ((col == n_in) ? DEF_MAX_INPUTS : col)] = sat16(val);
      end
      OP_INPUT: begin
        if (col < n_in) begin
          inputs_mem[col] = val;
          if (col == n_in - 1) begin
            for (int unsigned r = 0; r < n_out; r++) begin
              acc = weights[r*ROW_LEN + DEF_MAX_INPUTS] * 256;
              for (int unsigned c = 0; c < n_in; c++)
                acc += inputs_mem[c] * weights[r*ROW_LEN + c];
              z = sat16(round_q(acc, 8));
              o.result = (relu && z < 0) ? 16'd0 : z[15:0];
              o.position = r[5:0];
              o.direction = 1'b0;
              o.positive = (z > 0);
              o.last = (r == n_out - 1);
              layer_out_q.push_back(o);
            end
          end
        end
      end
      OP_DELTA: begin
        if (row < n_out) begin
          deltas_mem[row] = val;
          if (row == n_out - 1) begin
            for (int unsigned c = 0; c < n_in; c++) begin
              acc = 0;
              for (int unsigned r = 0; r < n_out; r++)
                acc += weights[r*ROW_LEN + c] * deltas_mem[r];
              z = sat16(round_q(acc, 8));
              o.result = z[15:0];
              o.position = c[5:0];
              o.direction = 1'b1;
              o.positive = 1'b0;
              o.last = (c == n_in - 1);
              layer_out_q.push_back(o);
            end
          end
        end
      end
      default: begin
        for (int unsigned r = 0; r < n_out; r++) begin
          ld = lr * deltas_mem[r];
          for (int unsigned c = 0; c < n_in; c++)
            weights[r*ROW_LEN + c] =
              sat16(weights[r*ROW_LEN + c] - round_q(ld * inputs_mem[c], 24));
          weights[r*ROW_LEN + DEF_MAX_INPUTS] =
            sat16(weights[r*ROW_LEN + DEF_MAX_INPUTS] - round_q(ld, 16));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    layer_out_t want;
    if (rst) begin
      n_in = DEF_MAX_INPUTS;
      n_out = DEF_MAX_OUTPUTS;
      lr = 655;
      relu = 1'b1;
      layer_out_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (layer_out_q.size() == 0) begin
          report("unexpected item", m_tdata[15:0], 16'd0);
        end else begin
          want = layer_out_q.pop_front();
          if (m_tdata[15:0] !== want.result) report("result", m_tdata[15:0], want.result);
          if (m_tdata[21:16] !== want.position)
            report("position", 16'(m_tdata[21:16]), 16'(want.position));
          if (m_tuser[0] !== want.direction)
            report("direction", 16'(m_tuser[0]), 16'(want.direction));
          if (m_tuser[1] !== want.positive)
            report("positive", 16'(m_tuser[1]), 16'(want.positive));
          if (m_tlast !== want.last) report("last", 16'(m_tlast), 16'(want.last));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_INPUTS: n_in = clamp_count(32'(cfg_data[6:0]), DEF_MAX_INPUTS);
          REG_NUM_OUTPUTS: n_out = clamp_count(32'(cfg_data[6:0]), DEF_MAX_OUTPUTS);
          REG_LEARNING_RATE: lr = longint'(cfg_data);
          REG_RELU_ENABLE: relu = cfg_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        run_layer_item(op_t'(s_tuser), 32'(s_tdata[5:0]), 32'(s_tdata[12:6]),
                       longint'($signed(s_tdata[28:13])));
    end
  end

endmodule

// ===== tb/dense_layer_train_engine_tb.sv =====
`timescale 1ns / 1ps

module dense_layer_train_engine_tb;
  import dltr_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [1:0]             m_tuser;
  logic                   m_tlast;
  int                     errors;
  int                     pending;
  int                     cycles;
  int                     hold_requests;
  bit                     no_idle;
  int unsigned            ni_cur;
  int unsigned            no_cur;
  int                     sent;

  dense_layer_train_engine u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  dense_layer_train_engine_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : sink
    int seen;
    seen = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        m_tready = 1'b0;
        repeat (600) @(negedge clk);
      end
      m_tready = no_idle || ($urandom_range(99) >= 33);
    end
  end

  function automatic logic [15:0] rand_val();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      1: return 16'($urandom);
      default: return 16'($urandom_range(0, 1023)) - 16'd512;
    endcase
  endfunction

  task automatic send_item(input op_t op, input int unsigned row, input int unsigned col,
                           input logic [15:0] v);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {3'b000, v, col[6:0], row[5:0]};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_NUM_INPUTS)
      ni_cur = (d[6:0] == 0) ? 1 : (d[6:0] > 64) ? 64 : d[6:0];
    if (idx == REG_NUM_OUTPUTS)
      no_cur = (d[6:0] == 0) ? 1 : (d[6:0] > 64) ? 64 : d[6:0];
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (no_cur*(ni_cur+7) + ni_cur*(no_cur+7) + no_cur*(ni_cur+2) + 20) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_count();
    case ($urandom_range(15))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [6:0] pick_small();
    return 7'($urandom_range(0, 4));
  endfunction

  function automatic logic [6:0] pick_one();
    return 7'($urandom_range(0, 1));
  endfunction

  initial begin : stimulus
    int phase;
    int nseq;
    logic [15:0] lr_val;
    logic [6:0]  ni_val;
    logic [6:0]  no_val;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_requests = 0;
    no_idle = 1'b0;
    ni_cur = 64;
    no_cur = 64;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sizes are kept to a 4 by 4 corner, a single row or a single column, so the
    // weights filled here are the bias of every row, column 0, row 0 and the corner.
    for (int r = 0; r < 64; r++) begin
      send_item(OP_WEIGHT, r, 64, rand_val());
      send_item(OP_WEIGHT, r, 0, rand_val());
    end
    for (int c = 1; c < 64; c++) send_item(OP_WEIGHT, 0, c, rand_val());
    for (int r = 1; r < 4; r++)
      for (int c = 1; c < 4; c++)
        send_item(OP_WEIGHT, r, c, rand_val());
    drain();

    cfg_write(REG_NUM_INPUTS, 16'h0004);
    cfg_write(REG_NUM_OUTPUTS, 16'h0004);
    for (int c = 0; c < 4; c++) begin
      if (c == 3) hold_requests++;
      send_item(OP_INPUT, 0, c, rand_val());
    end
    repeat (4) send_item(OP_WEIGHT, $urandom_range(3), $urandom_range(4), rand_val());
    drain();

    cfg_write(REG_NUM_INPUTS, 16'h007F);
    cfg_write(REG_NUM_OUTPUTS, 16'h0001);
    for (int c = 0; c < 64; c++) send_item(OP_INPUT, 0, c, rand_val());
    drain();

    cfg_write(REG_NUM_INPUTS, 16'h0001);
    cfg_write(REG_NUM_OUTPUTS, 16'h007F);
    for (int r = 0; r < 64; r++) send_item(OP_DELTA, r, 0, rand_val());
    send_item(OP_UPDATE, 0, 0, 16'h0000);
    drain();

    cfg_write(REG_NUM_INPUTS, 16'h0000);
    cfg_write(REG_NUM_OUTPUTS, 16'h0001);
    cfg_write(REG_RELU_ENABLE, 16'h0001);
    cfg_write(REG_LEARNING_RATE, 16'hFFFF);
    send_item(OP_WEIGHT, 0, 0, 16'h7FFF);
    send_item(OP_WEIGHT, 0, 1, 16'h8000);
    send_item(OP_WEIGHT, 63, 127, 16'h1234);
    send_item(OP_WEIGHT, 5, 0, 16'h4321);
    send_item(OP_INPUT, 0, 5, 16'h0100);
    send_item(OP_INPUT, 0, 0, 16'h7FFF);
    send_item(OP_INPUT, 0, 0, 16'h8000);
    drain();
    cfg_write(REG_RELU_ENABLE, 16'hFFFE);
    send_item(OP_INPUT, 0, 0, 16'h0100);
    send_item(OP_INPUT, 63, 0, 16'hFFFF);
    send_item(OP_DELTA, 9, 0, 16'h0100);
    send_item(OP_DELTA, 0, 0, 16'h8000);
    send_item(OP_DELTA, 0, 0, 16'h7FFF);
    send_item(OP_UPDATE, 0, 0, 16'h0000);
    send_item(OP_INPUT, 0, 0, 16'h0100);
    send_item(OP_DELTA, 0, 127, 16'hFFFF);
    drain();
    cfg_write(8'hFF, 16'hFFFF);
    cfg_write(REG_LEARNING_RATE, 16'h0000);
    send_item(OP_UPDATE, 63, 127, 16'hFFFF);
    send_item(OP_INPUT, 0, 0, 16'h0200);

    phase = 0;
    while (sent < 450) begin
      drain();
      no_idle = (phase == 1);
      case ($urandom_range(2))
        0: begin
          ni_val = pick_count();
          no_val = pick_one();
        end
        1: begin
          ni_val = pick_one();
          no_val = pick_count();
        end
        default: begin
          ni_val = pick_small();
          no_val = pick_small();
        end
      endcase
      cfg_write(REG_NUM_INPUTS, {9'($urandom), ni_val});
      cfg_write(REG_NUM_OUTPUTS, {9'($urandom), no_val});
      case ($urandom_range(3))
        0: lr_val = 16'h0000;
        1: lr_val = 16'hFFFF;
        default: lr_val = 16'($urandom);
      endcase
      cfg_write(REG_LEARNING_RATE, lr_val);
      cfg_write(REG_RELU_ENABLE, 16'($urandom));
      if ($urandom_range(3) == 0) cfg_write(8'($urandom_range(4, 255)), 16'($urandom));
      nseq = (ni_cur > 16 || no_cur > 16) ? 2 : $urandom_range(3, 8);
      for (int k = 0; k < nseq; k++) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: begin
            for (int c = 0; c < ni_cur; c++) begin
              if ($urandom_range(9) == 0)
                send_item(OP_WEIGHT, $urandom_range(no_cur - 1), $urandom_range(ni_cur),
                          rand_val());
              send_item(OP_INPUT, $urandom_range(63), c, rand_val());
            end
          end
          9, 10, 11, 12, 13, 14: begin
            for (int r = 0; r < no_cur; r++) begin
              send_item(OP_DELTA, r, $urandom_range(127), rand_val());
            end
          end
          15, 16: begin
            send_item(OP_UPDATE, $urandom_range(63), $urandom_range(127), rand_val());
          end
          default: begin
            repeat ($urandom_range(1, 4))
              send_item(op_t'($urandom_range(3)), $urandom_range(63), $urandom_range(127),
                        rand_val());
          end
        endcase
      end
      phase++;
    end
    no_idle = 1'b0;
    drain();

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
